### hdl/trdp_pkg.sv
`timescale 1ns / 1ps

package trdp_pkg;

  localparam int CountBits   = 16;
  localparam int OutAddrBits = 18;
  localparam int ByteBits    = 8;

  // A count word up to this value still has more than one byte left.
  localparam logic [CountBits-1:0] MaxPairCount = 16'hFFFE;

  typedef enum logic [1:0] {
    KIND_START     = 2'd0,
    KIND_DATA      = 2'd1,
    KIND_BUS_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_NONE      = 2'd0,
    STATUS_NORMAL    = 2'd1,
    STATUS_TOO_LONG  = 2'd2,
    STATUS_BUS_ERROR = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic [CountBits-1:0]   byte_count_word;
    logic [OutAddrBits-1:0] start_address;
    logic [ByteBits-1:0]    data_byte;
    logic                   last_byte;
  } in_item_t;

  typedef struct packed {
    logic                   write_valid;
    logic [OutAddrBits-1:0] write_address;
    logic [CountBits-1:0]   write_data;
    logic                   write_is_byte;
    logic [1:0]             status;
    logic [CountBits-1:0]   final_count;
    logic [OutAddrBits-1:0] final_address;
  } out_item_t;

endpackage

### hdl/trdp_if.sv
`timescale 1ns / 1ps

interface trdp_in_if;
  logic               valid;
  logic               ready;
  trdp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface trdp_out_if;
  logic                valid;
  logic                ready;
  trdp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/tape_read_dma_packer_core.sv
`timescale 1ns / 1ps
// Output: the result word for an accepted input word is registered and appears in the next cycle.
// Throughput: one input word per cycle; the output register is refilled in the
// same cycle its word is taken, so only a stalled output holds off the input.
// Reset: asynchronous and active low; it clears the count, address, held byte
// and record state, and empties the output register.

module tape_read_dma_packer_core #(
  parameter int ADDRESS_BITS = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  trdp_in_if.sink          in_i,
  trdp_out_if.source       out_o
);

  localparam int WideBits = (ADDRESS_BITS > trdp_pkg::OutAddrBits) ?
                            ADDRESS_BITS : trdp_pkg::OutAddrBits;

  logic [trdp_pkg::CountBits-1:0] count_q, count_d;
  logic [ADDRESS_BITS-1:0]        addr_q, addr_d;
  logic [trdp_pkg::ByteBits-1:0]  held_byte_q, held_byte_d;
  logic                           held_valid_q, held_valid_d;
  logic                           active_q, active_d;
  logic                           absorbing_q, absorbing_d;
  logic [1:0]                     pending_q, pending_d;
  logic                           out_valid_q, out_valid_d;
  trdp_pkg::out_item_t            out_item_q, out_item_d;

  logic                           in_fire;
  logic [1:0]                     step;
  trdp_pkg::status_e              status;
  logic [WideBits-1:0]            start_wide;
  logic [WideBits-1:0]            addr_wide;
  logic [WideBits-1:0]            addr_next_wide;

  assign in_i.ready    = !out_valid_q || out_o.ready;
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  assign start_wide     = WideBits'(in_i.payload.start_address);
  assign addr_wide      = WideBits'(addr_q);
  assign addr_next_wide = WideBits'(addr_d);

  always_comb begin
    count_d      = count_q;
    addr_d       = addr_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    active_d     = active_q;
    absorbing_d  = absorbing_q;
    pending_d    = pending_q;
    step         = 2'd0;
    status       = trdp_pkg::STATUS_NONE;
    out_item_d   = '0;

    unique case (in_i.payload.kind)
      trdp_pkg::KIND_START: begin
        count_d      = in_i.payload.byte_count_word;
        addr_d       = start_wide[ADDRESS_BITS-1:0];
        held_valid_d = 1'b0;
        active_d     = 1'b1;
        absorbing_d  = 1'b0;
        pending_d    = 2'd0;
      end
      trdp_pkg::KIND_DATA: begin
        if (active_q) begin
          if (held_valid_q) begin
            out_item_d.write_valid   = 1'b1;
            out_item_d.write_address = addr_wide[trdp_pkg::OutAddrBits-1:0];
            out_item_d.write_data    = {in_i.payload.data_byte, held_byte_q};
            held_valid_d             = 1'b0;
            step                     = 2'd2;
          end else if (count_q <= trdp_pkg::MaxPairCount && !addr_q[0] &&
                       !in_i.payload.last_byte) begin
            held_byte_d  = in_i.payload.data_byte;
            held_valid_d = 1'b1;
          end else begin
            out_item_d.write_valid   = 1'b1;
            out_item_d.write_address = addr_wide[trdp_pkg::OutAddrBits-1:0];
            out_item_d.write_data    = {{trdp_pkg::ByteBits{1'b0}}, in_i.payload.data_byte};
            out_item_d.write_is_byte = 1'b1;
            step                     = 2'd1;
          end
          if (step != 2'd0) begin
            count_d = count_q + trdp_pkg::CountBits'(step);
            addr_d  = addr_q + ADDRESS_BITS'(step);
            if (count_d == '0 && !in_i.payload.last_byte) begin
              status      = trdp_pkg::STATUS_TOO_LONG;
              active_d    = 1'b0;
              absorbing_d = 1'b1;
            end else if (in_i.payload.last_byte) begin
              status   = trdp_pkg::STATUS_NORMAL;
              active_d = 1'b0;
            end
          end
        end else if (absorbing_q && in_i.payload.last_byte) begin
          absorbing_d = 1'b0;
        end
        pending_d = step;
      end
      trdp_pkg::KIND_BUS_ERROR: begin
        if (pending_q != 2'd0) begin
          count_d      = count_q - trdp_pkg::CountBits'(pending_q);
          addr_d       = addr_q - ADDRESS_BITS'(pending_q);
          status       = trdp_pkg::STATUS_BUS_ERROR;
          absorbing_d  = active_q || absorbing_q;
          active_d     = 1'b0;
          held_valid_d = 1'b0;
        end
        pending_d = 2'd0;
      end
      default: begin
      end
    endcase

    out_item_d.status = status;
    if (status != trdp_pkg::STATUS_NONE) begin
      out_item_d.final_count   = count_d;
      out_item_d.final_address = addr_next_wide[trdp_pkg::OutAddrBits-1:0];
    end

    out_valid_d = in_fire || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      addr_q       <= '0;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      active_q     <= 1'b0;
      absorbing_q  <= 1'b0;
      pending_q    <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        count_q      <= count_d;
        addr_q       <= addr_d;
        held_byte_q  <= held_byte_d;
        held_valid_q <= held_valid_d;
        active_q     <= active_d;
        absorbing_q  <= absorbing_d;
        pending_q    <= pending_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

### hdl/trdp_checker.sv
`timescale 1ns / 1ps

module trdp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input trdp_pkg::out_item_t out_item_i
);

  // A stalled result word must hold still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result word changed while stalled");

  // Every accepted input word produces a result word in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result word after an accepted input word");

  // Word writes are only issued to even addresses.
  a_word_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.write_valid && !out_item_i.write_is_byte
    |-> !out_item_i.write_address[0])
    else $error("word write to an odd address");

  // Without a write, the write fields read as zero.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.write_valid
    |-> out_item_i.write_address == '0 && out_item_i.write_data == '0 &&
        !out_item_i.write_is_byte)
    else $error("write fields set without a write");

  // Final count and address are only reported with a nonzero status.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.status == trdp_pkg::STATUS_NONE
    |-> out_item_i.final_count == '0 && out_item_i.final_address == '0)
    else $error("final fields set without a status");

endmodule

bind tape_read_dma_packer_core trdp_checker u_trdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);

### sim/tape_read_dma_packer_core_test.sv
`timescale 1ns / 1ps

module tape_read_dma_packer_core_test;

  localparam int AddrBits = 18;
  localparam logic [1:0] KindIgnored = 2'd3;
  localparam int QuietLimit = 4000;
  localparam int ReportLimit = 10;
  localparam int TotalWords = 850;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  trdp_in_if in_if ();
  trdp_out_if out_if ();

  tape_read_dma_packer_core #(
    .ADDRESS_BITS(AddrBits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  // The expected transfer state, advanced once for every accepted input word.
  logic [trdp_pkg::CountBits-1:0] count_q = '0;
  logic [AddrBits-1:0] addr_q = '0;
  logic [trdp_pkg::ByteBits-1:0] held_q = '0;
  bit held_v = 1'b0;
  bit in_record = 1'b0;
  bit draining = 1'b0;
  logic [1:0] last_step = 2'd0;

  trdp_pkg::out_item_t outcomes_due[$];
  bit pacing_on = 1'b1;
  int words_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  function automatic int idle_len();
    if (!pacing_on || $urandom_range(99) < 60) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic trdp_pkg::out_item_t transfer_outcome(trdp_pkg::in_item_t w);
    trdp_pkg::out_item_t res;
    logic [1:0] step;
    trdp_pkg::status_e st;
    res = '0;
    step = 2'd0;
    st = trdp_pkg::STATUS_NONE;
    if (w.kind == KindIgnored) return res;
    case (w.kind)
      trdp_pkg::KIND_START: begin
        count_q = w.byte_count_word;
        addr_q = w.start_address[AddrBits-1:0];
        held_v = 1'b0;
        in_record = 1'b1;
        draining = 1'b0;
      end
      trdp_pkg::KIND_DATA: begin
        if (in_record) begin
          if (held_v) begin
            res.write_valid = 1'b1;
            res.write_address = addr_q;
            res.write_data = {w.data_byte, held_q};
            held_v = 1'b0;
            step = 2'd2;
          end else if (count_q <= trdp_pkg::MaxPairCount && !addr_q[0] &&
                       !w.last_byte) begin
            held_q = w.data_byte;
            held_v = 1'b1;
          end else begin
            res.write_valid = 1'b1;
            res.write_address = addr_q;
            res.write_data = {8'h00, w.data_byte};
            res.write_is_byte = 1'b1;
            step = 2'd1;
          end
          if (step != 2'd0) begin
            count_q = count_q + trdp_pkg::CountBits'(step);
            addr_q = addr_q + AddrBits'(step);
            if (count_q == '0 && !w.last_byte) begin
              st = trdp_pkg::STATUS_TOO_LONG;
              in_record = 1'b0;
              draining = 1'b1;
            end else if (w.last_byte) begin
              st = trdp_pkg::STATUS_NORMAL;
              in_record = 1'b0;
            end
          end
        end else if (draining && w.last_byte) begin
          draining = 1'b0;
        end
      end
      trdp_pkg::KIND_BUS_ERROR: begin
        if (last_step != 2'd0) begin
          count_q = count_q - trdp_pkg::CountBits'(last_step);
          addr_q = addr_q - AddrBits'(last_step);
          st = trdp_pkg::STATUS_BUS_ERROR;
          draining = in_record || draining;
          in_record = 1'b0;
          held_v = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (st != trdp_pkg::STATUS_NONE) begin
      res.status = st;
      res.final_count = count_q;
      res.final_address = addr_q;
    end
    last_step = step;
    return res;
  endfunction

  function automatic trdp_pkg::in_item_t start_word(logic [trdp_pkg::CountBits-1:0] cnt,
                                                    logic [trdp_pkg::OutAddrBits-1:0] addr);
    trdp_pkg::in_item_t w;
    w = '0;
    w.kind = trdp_pkg::KIND_START;
    w.byte_count_word = cnt;
    w.start_address = addr;
    return w;
  endfunction

  function automatic trdp_pkg::in_item_t data_word(logic [trdp_pkg::ByteBits-1:0] value,
                                                   bit last);
    trdp_pkg::in_item_t w;
    w = '0;
    w.kind = trdp_pkg::KIND_DATA;
    w.data_byte = value;
    w.last_byte = last;
    return w;
  endfunction

  function automatic trdp_pkg::in_item_t plain_word(logic [1:0] kind);
    trdp_pkg::in_item_t w;
    w = '0;
    w.kind = kind;
    return w;
  endfunction

  task automatic send_word(trdp_pkg::in_item_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    outcomes_due.push_back(transfer_outcome(w));
    words_sent++;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic check_outcome(trdp_pkg::out_item_t got);
    trdp_pkg::out_item_t want;
    if (outcomes_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("%0t: result word 0x%0h arrived with none expected", $time, got);
      return;
    end
    want = outcomes_due.pop_front();
    if (got.write_valid !== want.write_valid)
      note_mismatch("write_valid", want.write_valid, got.write_valid);
    if (got.write_address !== want.write_address)
      note_mismatch("write_address", want.write_address, got.write_address);
    if (got.write_data !== want.write_data)
      note_mismatch("write_data", want.write_data, got.write_data);
    if (got.write_is_byte !== want.write_is_byte)
      note_mismatch("write_is_byte", want.write_is_byte, got.write_is_byte);
    if (got.status !== want.status)
      note_mismatch("status", want.status, got.status);
    if (got.final_count !== want.final_count)
      note_mismatch("final_count", want.final_count, got.final_count);
    if (got.final_address !== want.final_address)
      note_mismatch("final_address", want.final_address, got.final_address);
  endtask

  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_outcome(out_if.payload);
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin : sink_pacing
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  task automatic test_word_pairing();
    send_word(start_word(16'hFFFC, 18'h00010));
    send_word(data_word(8'h11, 1'b0));
    send_word(data_word(8'h22, 1'b0));
    send_word(data_word(8'h33, 1'b0));
    send_word(data_word(8'h44, 1'b1));
  endtask

  // A zero count stands for a full 64K record; the odd top address wraps to zero.
  task automatic test_odd_address_wrap();
    send_word(start_word(16'h0000, 18'h3FFFF));
    send_word(data_word(8'hFF, 1'b0));
    send_word(data_word(8'h00, 1'b0));
    send_word(data_word(8'hA5, 1'b1));
  endtask

  task automatic test_too_long();
    send_word(start_word(16'hFFFD, 18'h3FFFE));
    send_word(data_word(8'h01, 1'b0));
    send_word(data_word(8'h02, 1'b0));
    send_word(data_word(8'h03, 1'b0));
    send_word(data_word(8'h04, 1'b0));
    send_word(data_word(8'h05, 1'b1));
    send_word(data_word(8'h06, 1'b1));
    send_word(plain_word(trdp_pkg::KIND_BUS_ERROR));
  endtask

  task automatic test_bus_error();
    send_word(start_word(16'hFFFE, 18'h00002));
    send_word(data_word(8'h80, 1'b0));
    send_word(plain_word(KindIgnored));
    send_word(data_word(8'h7F, 1'b1));
    send_word(plain_word(trdp_pkg::KIND_BUS_ERROR));
    send_word(plain_word(trdp_pkg::KIND_BUS_ERROR));
  endtask

  // A second start drops the held byte; a later bus error leaves the rest to be absorbed.
  task automatic test_restart();
    send_word(start_word(16'hFFF0, 18'h00100));
    send_word(data_word(8'hAA, 1'b0));
    send_word(start_word(16'hFFF8, 18'h00101));
    send_word(data_word(8'h55, 1'b0));
    send_word(plain_word(trdp_pkg::KIND_BUS_ERROR));
    send_word(data_word(8'h66, 1'b0));
    send_word(data_word(8'h67, 1'b1));
  endtask

  task automatic send_record();
    int planned;
    int n_bytes;
    logic [trdp_pkg::CountBits-1:0] cnt;
    planned = $urandom_range(24, 1);
    case ($urandom_range(9))
      0: cnt = trdp_pkg::CountBits'($urandom);
      1: cnt = '0;
      default: cnt = trdp_pkg::CountBits'(-planned);
    endcase
    n_bytes = planned;
    case ($urandom_range(7))
      0: n_bytes = planned + $urandom_range(6, 1);
      1: n_bytes = $urandom_range(planned, 1);
      default: begin
      end
    endcase
    send_word(start_word(cnt, trdp_pkg::OutAddrBits'($urandom)));
    for (int i = 0; i < n_bytes; i++) begin
      send_word(data_word(trdp_pkg::ByteBits'($urandom), i == n_bytes - 1));
      case ($urandom_range(39))
        0: send_word(plain_word(trdp_pkg::KIND_BUS_ERROR));
        1: send_word(plain_word(KindIgnored));
        2: send_word(start_word(trdp_pkg::CountBits'($urandom),
                                trdp_pkg::OutAddrBits'($urandom)));
        default: begin
        end
      endcase
    end
  endtask

  task automatic test_random_records(int target);
    while (words_sent < target) send_record();
  endtask

  task automatic test_random_noise(int target);
    logic [63:0] raw;
    trdp_pkg::in_item_t w;
    while (words_sent < target) begin
      raw = {$urandom, $urandom};
      w = raw[$bits(trdp_pkg::in_item_t)-1:0];
      send_word(w);
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_word_pairing();
    test_odd_address_wrap();
    test_too_long();
    test_bus_error();
    test_restart();
    pacing_on = 1'b0;
    test_random_records(words_sent + 200);
    pacing_on = 1'b1;
    test_random_records(TotalWords - 100);
    test_random_noise(TotalWords);
    in_if.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
